>>> src/ticket_reorder_buffer_assert.svh
// Assertion macros used by the reorder buffer checker.
`ifndef TICKET_REORDER_BUFFER_ASSERT_SVH
`define TICKET_REORDER_BUFFER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TRB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TRB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/trb_pkg.sv
// Shared types and constants of the ticket reorder buffer.
package trb_pkg;

   localparam int REQ_TDATA_WIDTH = 56;
   localparam int RSP_TDATA_WIDTH = 56;
   localparam int PAYLOAD_WIDTH   = 32;
   localparam int TICKET_WIDTH    = 4;
   localparam int STATUS_WIDTH    = 16;

   typedef logic [1:0]                       op_type;
   typedef logic [TICKET_WIDTH-1:0]          ticket_type;
   typedef logic [PAYLOAD_WIDTH-1:0]         payload_type;
   typedef logic signed [STATUS_WIDTH-1:0]   status_type;

   localparam op_type OP_SUBMIT   = 2'd0;
   localparam op_type OP_FETCH    = 2'd1;
   localparam op_type OP_COMPLETE = 2'd2;
   localparam op_type OP_RETIRE   = 2'd3;

   // latched request, ticket kept apart in its reduced form
   typedef struct packed {
      status_type  work_status;
      payload_type payload;
      op_type      operation;
   } req_type;

   // result item, lowest field last
   typedef struct packed {
      logic        empty_res;
      status_type  pool_status;
      payload_type data_out;
      ticket_type  ticket_out;
      logic        accepted;
   } rsp_type;

endpackage

>>> src/trb_slot_ram.sv
// Single-port-write, registered-read slot memory.
module trb_slot_ram #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/ticket_reorder_buffer.sv
// Result valid after slot memory read and write-back, later while an earlier result is held.
// One item in work at a time: slot memory read, then decide and write back.
// The input accepts again in the cycle after the write-back, even if the result still waits.
// Reset clears pointers, counts, latched status and the result valid.
// Payload and done memories have no reset: every slot is written by submit before its contents are used.
module ticket_reorder_buffer #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // payload[31:0], ticket[35:32], work_status[51:36], zero fill [55:52]
   input  logic [trb_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,
   // operation[1:0]
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // accepted[0], ticket_out[4:1], data_out[36:5], pool_status[52:37],
   // empty_res[53], zero fill [55:54]
   output logic [trb_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int TW = (AW > trb_pkg::TICKET_WIDTH) ? AW : trb_pkg::TICKET_WIDTH;
   localparam int XW = (DATA_WIDTH > trb_pkg::PAYLOAD_WIDTH) ?
                       DATA_WIDTH : trb_pkg::PAYLOAD_WIDTH;
   localparam int TK_STEPS = 8;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                 state_ff, state_in;
   trb_pkg::req_type     req_ff, req_in;
   logic [AW-1:0]        tk_ff, tk_in;
   logic [AW-1:0]        issue_ptr_ff, issue_ptr_in;
   logic [AW-1:0]        disp_ptr_ff, disp_ptr_in;
   logic [AW-1:0]        ret_ptr_ff, ret_ptr_in;
   logic [CW-1:0]        inflight_ff, inflight_in;
   logic [CW-1:0]        pending_ff, pending_in;
   trb_pkg::status_type  status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   trb_pkg::rsp_type     rsp_ff, rsp_in;

   logic                 in_fire;
   logic                 exec_fire;
   logic [TW:0]          tk_wide;
   logic [AW-1:0]        rd_addr;
   logic                 pay_wr_en;
   logic                 done_wr_en;
   logic [AW-1:0]        done_wr_addr;
   logic                 done_wr_data;
   logic [DATA_WIDTH-1:0] pay_rd;
   logic                 done_rd;

   logic                 ok;
   logic [AW-1:0]        tout_ptr;
   logic [TW-1:0]        tout_wide;
   logic [XW-1:0]        dout_wide;
   logic                 give_data;
   logic [AW:0]          off_sum;
   logic [AW:0]          offset;
   logic [CW-1:0]        dispatched;

   assign in_fire    = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign exec_fire  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_tready);

   // ticket mod DEPTH by repeated compare and subtract on a narrow value
   always_comb begin
      tk_wide = (TW + 1)'(req_tdata[35:32]);
      for (int i = 0; i < TK_STEPS; i++) begin
         if (tk_wide >= (TW + 1)'(DEPTH)) begin
            tk_wide = tk_wide - (TW + 1)'(DEPTH);
         end
      end
      tk_in = tk_wide[AW-1:0];
   end

   always_comb begin
      case (req_tuser)
         trb_pkg::OP_FETCH:    rd_addr = disp_ptr_ff;
         trb_pkg::OP_COMPLETE: rd_addr = tk_in;
         trb_pkg::OP_RETIRE:   rd_addr = ret_ptr_ff;
         default:              rd_addr = issue_ptr_ff;
      endcase
   end

   assign req_in = '{work_status: req_tdata[51:36],
                     payload:     req_tdata[31:0],
                     operation:   req_tuser};

   trb_slot_ram #(.DEPTH(DEPTH), .WIDTH(DATA_WIDTH)) u_payload_ram (
      .clock   (clock),
      .wr_en   (pay_wr_en),
      .wr_addr (issue_ptr_ff),
      .wr_data (DATA_WIDTH'(req_ff.payload)),
      .rd_en   (in_fire),
      .rd_addr (rd_addr),
      .rd_data (pay_rd)
   );

   trb_slot_ram #(.DEPTH(DEPTH), .WIDTH(1)) u_done_ram (
      .clock   (clock),
      .wr_en   (done_wr_en),
      .wr_addr (done_wr_addr),
      .wr_data (done_wr_data),
      .rd_en   (in_fire),
      .rd_addr (rd_addr),
      .rd_data (done_rd)
   );

   // window check for complete: ticket must lie among dispatched, unretired slots
   always_comb begin
      off_sum    = {1'b0, tk_ff} + (AW + 1)'(DEPTH) - {1'b0, ret_ptr_ff};
      offset     = (off_sum >= (AW + 1)'(DEPTH)) ? off_sum - (AW + 1)'(DEPTH) : off_sum;
      dispatched = inflight_ff - pending_ff;
   end

   always_comb begin
      ok           = 1'b0;
      tout_ptr     = '0;
      give_data    = 1'b0;
      issue_ptr_in = issue_ptr_ff;
      disp_ptr_in  = disp_ptr_ff;
      ret_ptr_in   = ret_ptr_ff;
      inflight_in  = inflight_ff;
      pending_in   = pending_ff;
      status_in    = status_ff;
      pay_wr_en    = 1'b0;
      done_wr_en   = 1'b0;
      done_wr_addr = tk_ff;
      done_wr_data = 1'b1;
      case (req_ff.operation)
         trb_pkg::OP_SUBMIT: begin
            ok       = (status_ff == '0) && (inflight_ff < CW'(DEPTH));
            tout_ptr = issue_ptr_ff;
            if (ok) begin
               pay_wr_en    = exec_fire;
               done_wr_en   = exec_fire;
               done_wr_addr = issue_ptr_ff;
               done_wr_data = 1'b0;
               issue_ptr_in = (issue_ptr_ff == AW'(DEPTH - 1)) ? '0 : issue_ptr_ff + 1'b1;
               inflight_in  = inflight_ff + 1'b1;
               pending_in   = pending_ff + 1'b1;
            end
         end
         trb_pkg::OP_FETCH: begin
            ok        = (status_ff == '0) && (pending_ff != '0);
            tout_ptr  = disp_ptr_ff;
            give_data = 1'b1;
            if (ok) begin
               disp_ptr_in = (disp_ptr_ff == AW'(DEPTH - 1)) ? '0 : disp_ptr_ff + 1'b1;
               pending_in  = pending_ff - 1'b1;
            end
         end
         trb_pkg::OP_COMPLETE: begin
            ok = (offset < (AW + 1)'(dispatched)) && !done_rd;
            if (ok) begin
               done_wr_en = exec_fire;
               if ((status_ff == '0) && (req_ff.work_status != '0)) begin
                  status_in = req_ff.work_status;
               end
            end
         end
         trb_pkg::OP_RETIRE: begin
            ok        = (inflight_ff != '0) && done_rd;
            give_data = 1'b1;
            if (ok) begin
               ret_ptr_in  = (ret_ptr_ff == AW'(DEPTH - 1)) ? '0 : ret_ptr_ff + 1'b1;
               inflight_in = inflight_ff - 1'b1;
            end
         end
         default: begin
            ok = 1'b0;
         end
      endcase
   end

   always_comb begin
      tout_wide = TW'(tout_ptr);
      dout_wide = XW'(pay_rd);
      rsp_in.accepted    = ok;
      rsp_in.ticket_out  = (ok && !give_data) || (ok && req_ff.operation == trb_pkg::OP_FETCH) ?
                           tout_wide[trb_pkg::TICKET_WIDTH-1:0] : '0;
      rsp_in.data_out    = (ok && give_data) ? dout_wide[trb_pkg::PAYLOAD_WIDTH-1:0] : '0;
      rsp_in.pool_status = status_in;
      rsp_in.empty_res   = (inflight_in == '0);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (in_fire) begin
         state_in = ST_EXEC;
      end else if (exec_fire) begin
         state_in     = ST_IDLE;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ptr_ff <= '0;
         disp_ptr_ff  <= '0;
         ret_ptr_ff   <= '0;
         inflight_ff  <= '0;
         pending_ff   <= '0;
         status_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_fire) begin
            issue_ptr_ff <= issue_ptr_in;
            disp_ptr_ff  <= disp_ptr_in;
            ret_ptr_ff   <= ret_ptr_in;
            inflight_ff  <= inflight_in;
            pending_ff   <= pending_in;
            status_ff    <= status_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         req_ff <= req_in;
         tk_ff  <= tk_in;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = trb_pkg::RSP_TDATA_WIDTH'(rsp_ff);

endmodule

>>> src/trb_checker.sv
// Port-level checker for the ticket reorder buffer, bound to the top level.
`include "ticket_reorder_buffer_assert.svh"

module trb_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [trb_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   `TRB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result item changed or dropped while stalled")

   // one item in work at a time: no accept right after an accept
   `TRB_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_tready, "input accepted while an item is in work")

   // a fresh result shows up only after its item was taken and went through the execute state
   `TRB_ASSERT_NOW(a_rsp_latency, clock, reset, $rose(rsp_tvalid), $past(req_fire, 2), "result appeared without a matching input item")

   // a refused operation hands out neither ticket nor data
   `TRB_ASSERT_NOW(a_refused_clean, clock, reset, rsp_fire && !rsp_tdata[0], rsp_tdata[36:1] == 36'd0, "refused result carries ticket or data")

endmodule

bind ticket_reorder_buffer trb_checker u_trb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
